// ----- hw/rtl/kkpt_pkg.sv -----
// Shared types and constants for the kana key preference table.
package kkpt_pkg;

    localparam int KEY_CHARS = 8;
    localparam int KEY_W     = 64;
    localparam int OFF_W     = 16;
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 7;
    localparam int IDX_W     = 6;

    localparam logic [LEN_W-1:0] KEY_LEN_MAX = 4'd15;
    localparam logic [7:0]       HIRA_PAGE   = 8'h24;
    localparam logic [7:0]       KATA_PAGE   = 8'h25;
    localparam logic [15:0]      KATA_LIMIT  = 16'h2574;
    localparam logic [7:0]       KANA_MARK   = 8'h80;

    localparam logic [2:0] MODE_PUSH     = 3'd0;
    localparam logic [2:0] MODE_LOOKUP   = 3'd1;
    localparam logic [2:0] MODE_REMEMBER = 3'd2;
    localparam logic [2:0] MODE_LOAD     = 3'd3;
    localparam logic [2:0] MODE_CLRFLAG  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADKANA = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOOKUP,
        OP_REMEMBER,
        OP_LOAD,
        OP_CLRFLAG
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_APPEND,
        S_EMIT
    } t_bstate;

    typedef struct packed {
        t_op              op;
        logic [1:0]       status;
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] off;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] off;
    } t_entry;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [14:0] preferred_offset;
        logic        updated;
    } t_res;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic nempty;
    } t_qctl;

endpackage

// ----- hw/rtl/kkpt_in_if.sv -----
// Input channel: one command transaction per handshake.
interface kkpt_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [15:0]        kana_code;
    logic [15:0]        candidate_offset;
    logic               is_last_candidate;
    logic [5:0]         load_index;
    logic [63:0]        load_key;
    logic signed [15:0] load_offset;

    modport source (output valid, mode, kana_code, candidate_offset, is_last_candidate,
                    load_index, load_key, load_offset, input ready);
    modport sink   (input valid, mode, kana_code, candidate_offset, is_last_candidate,
                    load_index, load_key, load_offset, output ready);
endinterface

// ----- hw/rtl/kkpt_out_if.sv -----
// Result channel: one result transaction per command.
interface kkpt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        hit;
    logic [14:0] preferred_offset;
    logic        updated;
    logic        table_changed;

    modport source (output valid, status, hit, preferred_offset, updated, table_changed,
                    input ready);
    modport sink   (input valid, status, hit, preferred_offset, updated, table_changed,
                     output ready);
endinterface

// ----- hw/rtl/kkpt_front.sv -----
// Front end: key buffer, input classification, command generation.
module kkpt_front
    import kkpt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_busy,
    input  logic          i_q_full,
    kkpt_in_if.sink       i_in,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic [KEY_W-1:0] r_key, n_key;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_bad, n_bad;
    logic             usable;
    logic             kana_ok;
    logic             bad_push;
    logic [7:0]       kbyte;
    t_cmd             cmd;

    assign i_in.ready = !i_q_full && !i_busy;
    assign o_push     = i_in.valid && i_in.ready;
    assign o_cmd      = cmd;

    always_comb begin
        n_key    = r_key;
        n_len    = r_len;
        n_bad    = r_bad;
        cmd      = '0;
        cmd.op   = OP_NOP;
        usable   = (r_len != '0) && (r_len <= LEN_W'(KEY_CHARS));
        kana_ok  = (i_in.kana_code[15:8] == HIRA_PAGE)
                || ((i_in.kana_code[15:8] == KATA_PAGE) && (i_in.kana_code < KATA_LIMIT));
        bad_push = r_bad || !kana_ok;
        kbyte    = i_in.kana_code[7:0] | KANA_MARK;
        case (i_in.mode)
            MODE_PUSH: begin
                n_bad = bad_push;
                for (int b = 0; b < KEY_CHARS; b++) begin
                    if (r_len == LEN_W'(b)) begin
                        n_key[8*b +: 8] = kbyte;
                    end
                end
                if (r_len != KEY_LEN_MAX) begin
                    n_len = r_len + LEN_W'(1);
                end
                cmd.status = bad_push ? ST_BADKANA : ST_OK;
            end
            MODE_LOOKUP, MODE_REMEMBER: begin
                cmd.key = r_key;
                cmd.off = {1'b0, i_in.candidate_offset[14:0]};
                if (usable && r_bad) begin
                    cmd.status = ST_BADKANA;
                end else if (usable && i_in.mode == MODE_LOOKUP) begin
                    cmd.op = OP_LOOKUP;
                end else if (usable && !i_in.is_last_candidate) begin
                    if (i_in.candidate_offset[15]) begin
                        cmd.status = ST_RANGE;
                    end else begin
                        cmd.op = OP_REMEMBER;
                    end
                end
                n_key = '0;
                n_len = '0;
                n_bad = 1'b0;
            end
            MODE_LOAD: begin
                cmd.op  = OP_LOAD;
                cmd.key = i_in.load_key;
                cmd.off = $unsigned(i_in.load_offset);
                cmd.idx = i_in.load_index;
            end
            MODE_CLRFLAG: begin
                cmd.op = OP_CLRFLAG;
            end
            default: begin
                cmd.op = OP_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_len <= '0;
            r_bad <= 1'b0;
        end else if (o_push) begin
            r_key <= n_key;
            r_len <= n_len;
            r_bad <= n_bad;
        end
    end

endmodule

// ----- hw/rtl/kkpt_queue.sv -----
// Two-entry command queue between front end and table engine.
module kkpt_queue
    import kkpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_qctl i_ctl,
    output t_qctl o_ctl,
    output t_cmd o_head
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_ctl.push   = 1'b0;
    assign o_ctl.pop    = 1'b0;
    assign o_ctl.full   = (r_cnt == 2'd2);
    assign o_ctl.nempty = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wp <= !r_wp;
            end
            if (i_ctl.pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_ctl.push) - 2'(i_ctl.pop);
        end
    end

endmodule

// ----- hw/rtl/kkpt_back.sv -----
// Table engine: entry memory, capacity register, search, shift and result register.
module kkpt_back
    import kkpt_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_q_nempty,
    input  t_cmd             i_head,
    output logic             o_pop,
    output logic             o_busy,
    kkpt_out_if.source       o_res
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CAP_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (CAP_W > CFG_W) ? CAP_W : CFG_W;

    t_entry           r_mem [MAX_ENTRIES];
    t_entry           r_rd_data;
    t_bstate          r_state, n_state;
    logic [CAP_W-1:0] r_idx, n_idx;
    logic [AW-1:0]    r_cmp_idx, n_cmp_idx;
    logic             r_pend, n_pend;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic             r_changed, n_changed;
    t_cmd             r_cmd, n_cmd;
    t_res             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;
    logic             r_out_chg, n_out_chg;

    logic             we;
    logic [AW-1:0]    waddr;
    t_entry           wdata;
    logic [AW-1:0]    rd_addr;
    logic [CAP_W-1:0] cap_last;
    logic             match;
    logic             at_last;
    logic             cfg_hit;
    logic             out_free;

    assign cap_last = r_cap - CAP_W'(1);
    assign match    = (r_rd_data.key == r_cmd.key);
    assign at_last  = (CAP_W'(r_cmp_idx) == cap_last);
    assign rd_addr  = r_idx[AW-1:0];
    assign out_free = !r_out_valid || o_res.ready;
    assign cfg_hit  = i_cfg_we && (i_cfg_wdata != '0)
                   && (CW'(i_cfg_wdata) <= CW'(MAX_ENTRIES))
                   && (CW'(i_cfg_wdata) != CW'(r_cap));
    assign o_busy   = (r_state == S_CLEAR);

    assign o_res.valid            = r_out_valid;
    assign o_res.status           = r_out.status;
    assign o_res.hit              = r_out.hit;
    assign o_res.preferred_offset = r_out.preferred_offset;
    assign o_res.updated          = r_out.updated;
    assign o_res.table_changed    = r_out_chg;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_pend      = r_pend;
        n_cap       = r_cap;
        n_changed   = r_changed;
        n_cmd       = r_cmd;
        n_res       = r_res;
        n_out       = r_out;
        n_out_chg   = r_out_chg;
        n_out_valid = r_out_valid && !o_res.ready;
        o_pop       = 1'b0;
        we          = 1'b0;
        waddr       = r_idx[AW-1:0];
        wdata       = '0;

        if (cfg_hit) begin
            n_cap     = CAP_W'(i_cfg_wdata);
            n_changed = 1'b1;
        end

        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                if (r_idx == CAP_W'(MAX_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CAP_W'(1);
                end
            end
            S_IDLE: begin
                if (cfg_hit) begin
                    if (CW'(i_cfg_wdata) < CW'(MAX_ENTRIES)) begin
                        n_idx   = CAP_W'(i_cfg_wdata);
                        n_state = S_CLEAR;
                    end
                end else if (i_q_nempty) begin
                    o_pop        = 1'b1;
                    n_cmd        = i_head;
                    n_res        = '0;
                    n_res.status = i_head.status;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    case (i_head.op)
                        OP_LOOKUP, OP_REMEMBER: begin
                            n_state = S_SEARCH;
                        end
                        OP_LOAD: begin
                            if (CW'(i_head.idx) < CW'(r_cap)) begin
                                we    = 1'b1;
                                waddr = AW'(i_head.idx);
                                wdata = '{key: i_head.key, off: i_head.off};
                            end
                            n_state = S_EMIT;
                        end
                        OP_CLRFLAG: begin
                            n_changed = 1'b0;
                            n_state   = S_EMIT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                n_pend    = (r_idx < r_cap);
                n_cmp_idx = r_idx[AW-1:0];
                if (r_idx < r_cap) begin
                    n_idx = r_idx + CAP_W'(1);
                end
                if (r_pend && match) begin
                    if (r_cmd.op == OP_LOOKUP) begin
                        if (!r_rd_data.off[15]) begin
                            n_res.hit              = 1'b1;
                            n_res.preferred_offset = r_rd_data.off[14:0];
                        end
                    end else if (r_rd_data.off != r_cmd.off) begin
                        we            = 1'b1;
                        waddr         = r_cmp_idx;
                        wdata         = '{key: r_rd_data.key, off: r_cmd.off};
                        n_changed     = 1'b1;
                        n_res.updated = 1'b1;
                    end
                    n_state = S_EMIT;
                end else if (r_pend && at_last) begin
                    if (r_cmd.op == OP_LOOKUP || r_cmd.off == '0) begin
                        n_state = S_EMIT;
                    end else if (r_cap == CAP_W'(1)) begin
                        n_state = S_APPEND;
                    end else begin
                        n_idx   = CAP_W'(1);
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                n_pend    = (r_idx < r_cap);
                n_cmp_idx = r_idx[AW-1:0];
                if (r_idx < r_cap) begin
                    n_idx = r_idx + CAP_W'(1);
                end
                if (r_pend) begin
                    we    = 1'b1;
                    waddr = r_cmp_idx - AW'(1);
                    wdata = r_rd_data;
                    if (at_last) begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_APPEND: begin
                we            = 1'b1;
                waddr         = cap_last[AW-1:0];
                wdata         = '{key: r_cmd.key, off: r_cmd.off};
                n_changed     = 1'b1;
                n_res.updated = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_chg   = r_changed;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_cmd     <= n_cmd;
        r_res     <= n_res;
        r_out     <= n_out;
        r_out_chg <= n_out_chg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_cap       <= CAP_W'(MAX_ENTRIES);
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_cap       <= n_cap;
            r_changed   <= n_changed;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hw/rtl/kana_key_preference_table_top.sv -----
// Kana key preference table: top level.
//
// i_in carries command transactions (push kana, lookup, remember, load entry,
// clear changed flag); o_res returns exactly one result transaction per command,
// in order. i_cfg_we/i_cfg_wdata write capacity_in_use; the user must do so only
// while idle, as the block itself does not enforce it. The front end builds the
// key and classifies each command in the cycle it is taken; a two-entry queue
// feeds the table engine, which walks the entry memory through its single read
// port, one entry per cycle.
// The engine takes one command at a time and holds it until its result enters
// the output register: push, load, flag clear and rejected commands go straight
// to the result; lookup and remember search the table, and remember of a new key
// also shifts the entries down and appends it.
// Reset and any accepted capacity write below MAX_ENTRIES start a clearing pass
// of the entry memory (all entries after reset, those from the new capacity up
// after a write) during which i_in.ready stays low.
// If o_res is stalled, one result waits in the output register, the engine
// holds the next one, and the queue fills; i_in.ready then drops.
module kana_key_preference_table_top
    import kkpt_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    kkpt_in_if.sink          i_in,
    kkpt_out_if.source       o_res
);

    t_cmd  front_cmd;
    t_cmd  q_head;
    t_qctl q_in_ctl;
    t_qctl q_out_ctl;
    logic  push;
    logic  pop;
    logic  busy;

    assign q_in_ctl.push   = push;
    assign q_in_ctl.pop    = pop;
    assign q_in_ctl.full   = 1'b0;
    assign q_in_ctl.nempty = 1'b0;

    kkpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_busy   (busy),
        .i_q_full (q_out_ctl.full),
        .i_in     (i_in),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    kkpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .i_ctl   (q_in_ctl),
        .o_ctl   (q_out_ctl),
        .o_head  (q_head)
    );

    kkpt_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_nempty  (q_out_ctl.nempty),
        .i_head      (q_head),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_res       (o_res)
    );

endmodule

// ----- sim/kana_key_preference_table_top_tb.sv -----
// Self-checking testbench for the kana key preference table under random backpressure.
`timescale 1ns / 100ps

module kana_key_preference_table_top_tb;
    import kkpt_pkg::*;

    localparam int ENTRIES = 64;
    localparam int POOL = 16;
    localparam int PHASE_ITEMS = 150;
    localparam int LIMIT = 1000000;
    localparam int LONGEST_KEY = 16;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        kana_code;
        logic [15:0]        cand_offset;
        logic               last_cand;
        logic [5:0]         load_index;
        logic [63:0]        load_key;
        logic signed [15:0] load_offset;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [14:0] pref;
        logic        updated;
        logic        changed;
    } reply_t;

    class pref_table_sb;
        logic [63:0] keys[ENTRIES];
        logic [15:0] offs[ENTRIES];
        logic [63:0] kbuf;
        int unsigned klen;
        bit          bad;
        bit          chg;
        int unsigned cap;
        reply_t      pending_replies[$];
        int          errors;
        int          n_hits;
        int          n_updates;

        function new();
            foreach (keys[i]) begin
                keys[i] = '0;
                offs[i] = '0;
            end
            kbuf = '0;
            klen = 0;
            bad = 0;
            chg = 0;
            cap = ENTRIES;
            errors = 0;
            n_hits = 0;
            n_updates = 0;
        endfunction

        function int find_key(logic [63:0] k);
            for (int i = 0; i < cap; i++)
                if (keys[i] == k) return i;
            return -1;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] v);
            if (v == 0 || v > ENTRIES || v == cap) return;
            for (int i = v; i < ENTRIES; i++) begin
                keys[i] = '0;
                offs[i] = '0;
            end
            cap = v;
            chg = 1;
        endfunction

        function reply_t predict_reply(cmd_t c);
            reply_t     r;
            int         hit_at;
            bit         usable;
            logic [7:0] page;
            r = '0;
            case (c.mode)
                MODE_PUSH: begin
                    page = c.kana_code[15:8];
                    if (page != HIRA_PAGE && (page != KATA_PAGE || c.kana_code >= KATA_LIMIT))
                        bad = 1;
                    if (klen < KEY_CHARS) kbuf[8*klen +: 8] = c.kana_code[7:0] | KANA_MARK;
                    if (klen < KEY_LEN_MAX) klen++;
                    r.status = bad ? ST_BADKANA : ST_OK;
                end
                MODE_LOOKUP, MODE_REMEMBER: begin
                    usable = klen != 0 && klen <= KEY_CHARS;
                    if (usable && bad) begin
                        r.status = ST_BADKANA;
                    end else if (usable && c.mode == MODE_LOOKUP) begin
                        hit_at = find_key(kbuf);
                        if (hit_at >= 0 && !offs[hit_at][15]) begin
                            r.hit = 1;
                            r.pref = offs[hit_at][14:0];
                        end
                    end else if (usable && !c.last_cand) begin
                        if (c.cand_offset[15]) begin
                            r.status = ST_RANGE;
                        end else begin
                            hit_at = find_key(kbuf);
                            if (hit_at >= 0) begin
                                if (offs[hit_at] != c.cand_offset) begin
                                    offs[hit_at] = c.cand_offset;
                                    chg = 1;
                                    r.updated = 1;
                                end
                            end else if (c.cand_offset != 0) begin
                                for (int i = 0; i + 1 < cap; i++) begin
                                    keys[i] = keys[i+1];
                                    offs[i] = offs[i+1];
                                end
                                keys[cap-1] = kbuf;
                                offs[cap-1] = c.cand_offset;
                                chg = 1;
                                r.updated = 1;
                            end
                        end
                    end
                    kbuf = '0;
                    klen = 0;
                    bad = 0;
                end
                MODE_LOAD: begin
                    if (c.load_index < cap) begin
                        keys[c.load_index] = c.load_key;
                        offs[c.load_index] = c.load_offset;
                    end
                end
                MODE_CLRFLAG: chg = 0;
                default: ;
            endcase
            r.changed = chg;
            n_hits += r.hit;
            n_updates += r.updated;
            return r;
        endfunction

        function void take_command(cmd_t c);
            pending_replies.push_back(predict_reply(c));
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.hit != want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.pref != want.pref) begin
                $error("preferred_offset: expected %0d, got %0d", want.pref, got.pref);
                errors++;
            end
            if (got.updated != want.updated) begin
                $error("updated: expected %0d, got %0d", want.updated, got.updated);
                errors++;
            end
            if (got.changed != want.changed) begin
                $error("table_changed: expected %0d, got %0d", want.changed, got.changed);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    kkpt_in_if  in_ch ();
    kkpt_out_if res_ch ();

    kana_key_preference_table_top #(.MAX_ENTRIES(ENTRIES)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_res       (res_ch)
    );

    pref_table_sb sb = new();
    bit           calm = 0;
    int           sent = 0;
    int           cap_writes = 0;
    int           cycles = 0;
    logic [15:0]  pool_chars[POOL][KEY_CHARS];
    int           pool_len[POOL];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk)
        res_ch.ready <= calm || ($urandom_range(99) >= 31);

    // Both handshakes are observed here, at the edge where they complete.
    always @(posedge i_clk) begin
        cmd_t   c;
        reply_t r;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                c.mode        = in_ch.mode;
                c.kana_code   = in_ch.kana_code;
                c.cand_offset = in_ch.candidate_offset;
                c.last_cand   = in_ch.is_last_candidate;
                c.load_index  = in_ch.load_index;
                c.load_key    = in_ch.load_key;
                c.load_offset = in_ch.load_offset;
                sb.take_command(c);
            end
            if (res_ch.valid && res_ch.ready) begin
                r.status  = res_ch.status;
                r.hit     = res_ch.hit;
                r.pref    = res_ch.preferred_offset;
                r.updated = res_ch.updated;
                r.changed = res_ch.table_changed;
                sb.check_reply(r);
            end
        end
    end

    function automatic cmd_t noise_cmd(logic [2:0] m);
        cmd_t c;
        c.mode        = m;
        c.kana_code   = 16'($urandom);
        c.cand_offset = 16'($urandom);
        c.last_cand   = 1'($urandom);
        c.load_index  = 6'($urandom);
        c.load_key    = {$urandom, $urandom};
        c.load_offset = 16'($urandom);
        return c;
    endfunction

    function automatic logic [15:0] good_kana();
        if ($urandom_range(1)) return {HIRA_PAGE, 8'($urandom)};
        return {KATA_PAGE, 8'($urandom_range(KATA_LIMIT[7:0] - 8'd1))};
    endfunction

    function automatic logic [63:0] pool_key(int k);
        logic [63:0] key;
        key = '0;
        for (int j = 0; j < pool_len[k]; j++)
            key[8*j +: 8] = pool_chars[k][j][7:0] | KANA_MARK;
        return key;
    endfunction

    function automatic logic [15:0] remember_offset();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return 16'($urandom_range(16'h8000, 16'hFFFF));
        if (r < 30) return 16'($urandom_range(1, 16));
        return 16'($urandom_range(1, 16'h7FFF));
    endfunction

    function automatic logic [2:0] side_mode();
        case ($urandom_range(2))
            0: return MODE_LOAD;
            1: return MODE_CLRFLAG;
            default: return 3'(MODE_CLRFLAG + 1 + $urandom_range(2));
        endcase
    endfunction

    task automatic send_cmd(input cmd_t c);
        if (!calm)
            while ($urandom_range(99) < 31) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        in_ch.valid             <= 1'b1;
        in_ch.mode              <= c.mode;
        in_ch.kana_code         <= c.kana_code;
        in_ch.candidate_offset  <= c.cand_offset;
        in_ch.is_last_candidate <= c.last_cand;
        in_ch.load_index        <= c.load_index;
        in_ch.load_key          <= c.load_key;
        in_ch.load_offset       <= c.load_offset;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic push_char(input logic [15:0] code);
        cmd_t c;
        c = noise_cmd(MODE_PUSH);
        c.kana_code = code;
        send_cmd(c);
    endtask

    task automatic finish_key(input logic [2:0] m, input logic [15:0] off, input logic last);
        cmd_t c;
        c = noise_cmd(m);
        c.cand_offset = off;
        c.last_cand = last;
        send_cmd(c);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_capacity(v);
        cap_writes++;
        i_cfg_we <= 1'b0;
    endtask

    // Build a key, mostly well formed, then usually consume it.
    task automatic key_sequence();
        cmd_t        c;
        int          k;
        int          n;
        int          pick;
        logic [15:0] chars[LONGEST_KEY];
        k = $urandom_range(POOL - 1);
        foreach (chars[j]) chars[j] = good_kana();
        if ($urandom_range(99) < 70) begin
            n = pool_len[k];
            for (int j = 0; j < n; j++) chars[j] = pool_chars[k][j];
        end else begin
            n = $urandom_range(1, KEY_CHARS);
        end
        if ($urandom_range(99) < 6) n = $urandom_range(KEY_CHARS + 1, LONGEST_KEY);
        if ($urandom_range(99) < 8) chars[$urandom_range(n - 1)] = 16'($urandom);
        for (int j = 0; j < n; j++) push_char(chars[j]);
        pick = $urandom_range(99);
        if (pick < 45) begin
            c = noise_cmd(MODE_LOOKUP);
        end else if (pick < 92) begin
            c = noise_cmd(MODE_REMEMBER);
            c.cand_offset = remember_offset();
            c.last_cand = $urandom_range(99) < 8;
        end else begin
            c = noise_cmd(side_mode());
        end
        send_cmd(c);
    endtask

    task automatic side_item();
        cmd_t c;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            c = noise_cmd(MODE_LOAD);
            c.load_key = pool_key($urandom_range(POOL - 1));
        end else if (pick < 70) begin
            c = noise_cmd(side_mode());
        end else begin
            c = noise_cmd($urandom_range(1) ? MODE_LOOKUP : MODE_REMEMBER);
        end
        send_cmd(c);
    endtask

    initial begin
        logic [CFG_W-1:0] caps[11];
        cmd_t             c;
        int               target;
        caps = '{7'd8, 7'd1, 7'd0, 7'd64, 7'd3, 7'd100, 7'd2, 7'd127, 7'd64, 7'd16, 7'd64};
        for (int k = 0; k < POOL; k++) begin
            pool_len[k] = (k < POOL / 2) ? $urandom_range(1, 3) : $urandom_range(1, KEY_CHARS);
            for (int j = 0; j < KEY_CHARS; j++) pool_chars[k][j] = good_kana();
        end
        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_wdata             <= '0;
        in_ch.valid             <= 1'b0;
        in_ch.mode              <= MODE_PUSH;
        in_ch.kana_code         <= '0;
        in_ch.candidate_offset  <= '0;
        in_ch.is_last_candidate <= 1'b0;
        in_ch.load_index        <= '0;
        in_ch.load_key          <= '0;
        in_ch.load_offset       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_capacity(7'd64);
        finish_key(MODE_LOOKUP, 16'd5, 1'b0);
        push_char(16'h2400);
        push_char(16'h2573);
        finish_key(MODE_REMEMBER, 16'h7FFF, 1'b0);
        push_char(16'h2400);
        push_char(16'h2573);
        finish_key(MODE_LOOKUP, 16'd0, 1'b0);
        push_char(16'h24FF);
        push_char(16'h2500);
        finish_key(MODE_LOOKUP, 16'd0, 1'b0);
        push_char(16'h2574);
        finish_key(MODE_REMEMBER, 16'd5, 1'b0);
        push_char(16'h2500);
        finish_key(MODE_REMEMBER, 16'h8000, 1'b0);
        push_char(16'h2401);
        finish_key(MODE_REMEMBER, 16'd0, 1'b0);
        push_char(16'h2401);
        finish_key(MODE_REMEMBER, 16'd9, 1'b1);
        // negative stored offset must read back as a miss
        c = noise_cmd(MODE_LOAD);
        c.load_index = 6'(ENTRIES - 1);
        c.load_key = {56'd0, 8'h01 | KANA_MARK};
        c.load_offset = 16'sh8000;
        send_cmd(c);
        push_char(16'h2401);
        finish_key(MODE_LOOKUP, 16'd0, 1'b0);
        finish_key(MODE_REMEMBER, 16'd3, 1'b0);
        send_cmd(noise_cmd(MODE_CLRFLAG));
        send_cmd(noise_cmd(3'(MODE_CLRFLAG + 3)));

        foreach (caps[p]) begin
            write_capacity(caps[p]);
            calm = (p == 3);
            target = sent + PHASE_ITEMS;
            while (sent < target)
                if ($urandom_range(99) < 12) side_item();
                else key_sequence();
        end
        calm = 0;

        drain();
        repeat (2 * ENTRIES + 10) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            $error("%0d result transactions never arrived", sb.outstanding());
            sb.errors++;
        end
        $display("Ran %0d commands across %0d capacity writes (1 to 64 and rejected values).",
                 sent, cap_writes);
        $display("Saw %0d lookup hits and %0d table updates.", sb.n_hits, sb.n_updates);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
